// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker of the power leveler.
// Depends on signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define RFPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define RFPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define RFPL_ASSERT_NEXT_ALL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rfpl_pkg.sv -----
// Package for the RF output power leveler: types, widths, register indexes
// and reset values. No dependencies.
package rfpl_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LEVEL_W    = 6;
  localparam int ADC_W      = 16;
  localparam int PWR_W      = 16;
  localparam int CHAN_W     = 4;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_LEVEL   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEVEL   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_LEVEL  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DET_SLOPE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DET_ICEPT   = 3'd4;

  localparam logic [LEVEL_W-1:0]       MIN_LEVEL_RST  = 6'd0;
  localparam logic [LEVEL_W-1:0]       MAX_LEVEL_RST  = 6'd63;
  localparam logic [LEVEL_W-1:0]       STEP_LEVEL_RST = 6'd1;
  localparam logic [CFG_DATA_W-1:0]    SLOPE_RST      = 16'd37509;
  localparam logic signed [PWR_W-1:0]  ICEPT_RST      = 16'sd10240;

  localparam logic [CHAN_W-1:0] DET_CHANNEL = 4'd5;

  localparam logic MODE_SETPOINT = 1'b0;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_FIRST = 4'b0010,
    PH_RAISE = 4'b0100,
    PH_LOWER = 4'b1000
  } run_phase_t;

endpackage

// ----- src/rf_output_power_leveler_unit.sv -----
// RF output power leveler, top level: input register, leveling logic and
// result register in one module. Depends on rfpl_pkg.
//
// Usage: the slave stream (s_tvalid/s_tready) takes one beat per item. With
// s_tuser low the beat is a setpoint in Q8 dBm; it selects synthesizer power
// and starts a leveling run, and always gives one result beat. With s_tuser
// high the beat is a detector sample; samples tagged channel 5 are averaged
// over AVG_SAMPLES, and each full average gives one result beat, stepping the
// attenuator when a run is active. Other samples give no result.
// The master stream (m_tvalid/m_tready) carries the result beats.
// A beat accepted sits in the input register; its result is loaded into the
// result register once that register is free or being emptied. Throughput is
// one beat per cycle unless m_tready low holds a result; the limit is the
// combinational path from the input register through the detector multiply,
// compare and step into the result register. The sample divide by AVG_SAMPLES
// is split into a reciprocal multiply at the input port and a running quotient
// and remainder, so no wide sum is kept. Stall: while a result waits and
// m_tready is low, one more beat is held in the input register, then s_tready
// drops until the result is taken. Reset (rst, synchronous, active high)
// restores register defaults, sets the attenuator to full attenuation, idles the
// run and empties both stages. The user writes configuration through
// cfg_we/cfg_addr/cfg_wdata while idle; the block does not enforce it.
module rf_output_power_leveler_unit #(
  parameter int AVG_SAMPLES = 8,
  parameter int ATTEN_BITS  = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rfpl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rfpl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: target_q8[15:0], adc_sample[31:16], adc_channel[35:32], zero pad
  input  logic [rfpl_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: mode (0 setpoint, 1 detector sample)
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: level_now[5:0], atten_code[11:6], measured_q8[27:12],
  //          synth_high_power[28], settled[29], out_of_range[30], zero pad
  output logic [rfpl_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import rfpl_pkg::*;

  // Width of the sample quotient remainder and of the sample counter.
  localparam int FW = $clog2(AVG_SAMPLES);
  // Exact reciprocal for dividing a 16-bit sample by AVG_SAMPLES.
  localparam int RECIP_SHIFT = ADC_W + FW;
  localparam int RECIP_W     = ADC_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES);
  localparam logic [FW:0]   AVG_N    = (FW+1)'(AVG_SAMPLES);
  localparam logic [FW-1:0] CNT_LAST = FW'(AVG_SAMPLES - 1);
  // Level arithmetic width: room for the wider of level and register plus carry.
  localparam int WW = ((ATTEN_BITS > LEVEL_W) ? ATTEN_BITS : LEVEL_W) + 1;
  localparam logic [ATTEN_BITS-1:0] LEVEL_RST = ATTEN_BITS'(63);

  // Configuration registers.
  logic [LEVEL_W-1:0]       min_level;
  logic [LEVEL_W-1:0]       max_level;
  logic [LEVEL_W-1:0]       step_level;
  logic [CFG_DATA_W-1:0]    detector_slope;
  logic signed [PWR_W-1:0]  detector_intercept;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level          <= MIN_LEVEL_RST;
      max_level          <= MAX_LEVEL_RST;
      step_level         <= STEP_LEVEL_RST;
      detector_slope     <= SLOPE_RST;
      detector_intercept <= ICEPT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_LEVEL:  min_level          <= cfg_wdata[LEVEL_W-1:0];
        REG_MAX_LEVEL:  max_level          <= cfg_wdata[LEVEL_W-1:0];
        REG_STEP_LEVEL: step_level         <= cfg_wdata[LEVEL_W-1:0];
        REG_DET_SLOPE:  detector_slope     <= cfg_wdata;
        REG_DET_ICEPT:  detector_intercept <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Port-side predivide of the sample: quotient and remainder by AVG_SAMPLES.
  logic [ADC_W-1:0]         in_sample;
  logic [ADC_W+RECIP_W-1:0] in_prod;
  logic [ADC_W-1:0]         in_sq;
  logic [FW-1:0]            in_sr;

  assign in_sample = s_tdata[31:16];
  assign in_prod   = in_sample * RECIP;
  assign in_sq     = ADC_W'(in_prod >> RECIP_SHIFT);
  assign in_sr     = in_sample[FW-1:0] - FW'(in_sq * AVG_N);

  // Input register stage.
  logic                     ir_valid;
  logic                     ir_mode;
  logic signed [PWR_W-1:0]  ir_target;
  logic                     ir_chan_ok;
  logic [ADC_W-1:0]         ir_sq;
  logic [FW-1:0]            ir_sr;
  logic                     in_accept;
  logic                     proc_en;

  // The held item moves on when the result register is free or being emptied.
  assign proc_en   = ir_valid && (!m_tvalid || m_tready);
  assign s_tready  = !ir_valid || proc_en;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_accept) begin
      ir_valid <= 1'b1;
    end else if (proc_en) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ir_mode    <= s_tuser;
      ir_target  <= $signed(s_tdata[15:0]);
      ir_chan_ok <= (s_tdata[35:32] == DET_CHANNEL);
      ir_sq      <= in_sq;
      ir_sr      <= in_sr;
    end
  end

  // Leveling state.
  logic [ATTEN_BITS-1:0]    atten_level, atten_level_next;
  logic [ADC_W-1:0]         acc_quot, acc_quot_next;
  logic [FW-1:0]            acc_rem, acc_rem_next;
  logic [FW-1:0]            sample_count, sample_count_next;
  run_phase_t               run_phase, run_phase_next;
  logic signed [PWR_W-1:0]  target_power, target_power_next;
  logic signed [PWR_W-1:0]  meas_power, meas_power_next;
  logic                     synth_hi, synth_hi_next;
  logic                     settled, settled_next;
  logic                     out_of_range, out_of_range_next;
  logic                     res_fire;

  // Running quotient update and detected power for this sample.
  logic [FW:0]              rem_sum;
  logic                     rem_carry;
  logic [ADC_W-1:0]         avg_new;
  logic [FW-1:0]            rem_new;
  logic [2*ADC_W-1:0]       drop_prod;
  logic signed [PWR_W+1:0]  pwr_wide;
  logic signed [PWR_W-1:0]  pwr;

  assign rem_sum   = {1'b0, acc_rem} + {1'b0, ir_sr};
  assign rem_carry = (rem_sum >= AVG_N);
  assign rem_new   = rem_carry ? FW'(rem_sum - AVG_N) : rem_sum[FW-1:0];
  assign avg_new   = acc_quot + ir_sq + ADC_W'(rem_carry);
  assign drop_prod = detector_slope * avg_new;
  assign pwr_wide  = (PWR_W+2)'(detector_intercept)
                   - $signed({2'b00, drop_prod[2*ADC_W-1:ADC_W]});
  // The drop is never negative, so only the low side can saturate.
  assign pwr = (pwr_wide < -(PWR_W+2)'(32768)) ? -PWR_W'(32768)
                                                : pwr_wide[PWR_W-1:0];

  // Band edges and level stepping operands.
  logic [LEVEL_W-1:0]       step_eff;
  logic signed [PWR_W+1:0]  band;
  logic signed [PWR_W+1:0]  tgt_wide;
  logic signed [PWR_W+1:0]  pwr_ext;
  logic [WW-1:0]            lvl_w;
  logic [WW-1:0]            max_w;
  logic [WW-1:0]            min_w;
  logic [WW-1:0]            step_w;
  logic [WW-1:0]            raise_sum;
  logic [WW-1:0]            raise_lvl;
  logic [WW-1:0]            lower_lvl;

  assign step_eff  = (step_level == '0) ? LEVEL_W'(1) : step_level;
  assign band      = $signed({5'b0, step_eff, 7'b0});
  assign tgt_wide  = (PWR_W+2)'(target_power);
  assign pwr_ext   = (PWR_W+2)'(pwr);
  assign lvl_w     = WW'(atten_level);
  assign max_w     = WW'(max_level);
  assign min_w     = WW'(min_level);
  assign step_w    = WW'(step_eff);
  assign raise_sum = lvl_w + step_w;
  assign raise_lvl = (raise_sum > max_w) ? max_w : raise_sum;
  assign lower_lvl = (lvl_w >= min_w + step_w) ? (lvl_w - step_w) : min_w;

  run_phase_t work_phase;

  always_comb begin
    atten_level_next  = atten_level;
    acc_quot_next     = acc_quot;
    acc_rem_next      = acc_rem;
    sample_count_next = sample_count;
    run_phase_next    = run_phase;
    target_power_next = target_power;
    meas_power_next   = meas_power;
    synth_hi_next     = synth_hi;
    settled_next      = settled;
    out_of_range_next = out_of_range;
    res_fire          = 1'b0;
    work_phase        = run_phase;

    if (proc_en) begin
      if (ir_mode == MODE_SETPOINT) begin
        // A new setpoint restarts the run from a clean accumulator.
        target_power_next = ir_target;
        synth_hi_next     = !ir_target[PWR_W-1];
        acc_quot_next     = '0;
        acc_rem_next      = '0;
        sample_count_next = '0;
        settled_next      = 1'b0;
        out_of_range_next = 1'b0;
        run_phase_next    = PH_FIRST;
        res_fire          = 1'b1;
      end else if (ir_chan_ok) begin
        acc_quot_next     = avg_new;
        acc_rem_next      = rem_new;
        sample_count_next = sample_count + FW'(1);
        if (sample_count == CNT_LAST) begin
          acc_quot_next     = '0;
          acc_rem_next      = '0;
          sample_count_next = '0;
          meas_power_next   = pwr;
          res_fire          = 1'b1;

          // The first average of a run locks the direction.
          if (run_phase == PH_FIRST) begin
            if (pwr > target_power) begin
              work_phase = PH_RAISE;
            end else if (pwr < target_power) begin
              work_phase = PH_LOWER;
            end else begin
              work_phase        = PH_IDLE;
              settled_next      = 1'b1;
              out_of_range_next = 1'b0;
              run_phase_next    = PH_IDLE;
            end
          end

          unique case (work_phase)
            PH_RAISE: begin
              run_phase_next = PH_RAISE;
              if (pwr_ext > tgt_wide + band) begin
                if (lvl_w < max_w) begin
                  atten_level_next = raise_lvl[ATTEN_BITS-1:0];
                end else begin
                  settled_next      = 1'b0;
                  out_of_range_next = 1'b1;
                  run_phase_next    = PH_IDLE;
                end
              end else begin
                settled_next      = 1'b1;
                out_of_range_next = 1'b0;
                run_phase_next    = PH_IDLE;
              end
            end
            PH_LOWER: begin
              run_phase_next = PH_LOWER;
              if (pwr_ext < tgt_wide - band) begin
                if (lvl_w > min_w) begin
                  atten_level_next = lower_lvl[ATTEN_BITS-1:0];
                end else begin
                  settled_next      = 1'b0;
                  out_of_range_next = 1'b1;
                  run_phase_next    = PH_IDLE;
                end
              end else begin
                settled_next      = 1'b1;
                out_of_range_next = 1'b0;
                run_phase_next    = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atten_level  <= LEVEL_RST;
      acc_quot     <= '0;
      acc_rem      <= '0;
      sample_count <= '0;
      run_phase    <= PH_IDLE;
      target_power <= '0;
      meas_power   <= '0;
      synth_hi     <= 1'b0;
      settled      <= 1'b0;
      out_of_range <= 1'b0;
    end else begin
      atten_level  <= atten_level_next;
      acc_quot     <= acc_quot_next;
      acc_rem      <= acc_rem_next;
      sample_count <= sample_count_next;
      run_phase    <= run_phase_next;
      target_power <= target_power_next;
      meas_power   <= meas_power_next;
      synth_hi     <= synth_hi_next;
      settled      <= settled_next;
      out_of_range <= out_of_range_next;
    end
  end

  // Result register. The level is shown in six bits whatever ATTEN_BITS is.
  logic [WW-1:0] lvl_out;
  logic [WW-1:0] code_out;

  assign lvl_out  = WW'(atten_level_next);
  assign code_out = WW'(~atten_level_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      m_tdata <= {1'b0, out_of_range_next, settled_next, synth_hi_next,
                  meas_power_next, code_out[LEVEL_W-1:0], lvl_out[LEVEL_W-1:0]};
    end
  end

endmodule

// ----- src/rfpl_checker.sv -----
// Port-level checker for the RF output power leveler, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rfpl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A run ends one way only: never settled and out of range together.
  `RFPL_ASSERT_NOW(a_one_outcome, m_tvalid, !(m_tdata[29] && m_tdata[30]), "both run flags set")

  // Input back-pressure only comes from a result that the receiver holds off.
  `RFPL_ASSERT_NOW(a_ready_cause, !s_tready, m_tvalid && !m_tready, "input stalled without cause")

  // A stalled result beat stays put.
  `RFPL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Reset empties both stages.
  `RFPL_ASSERT_NEXT_ALL(a_reset_empty, rst, !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule

bind rf_output_power_leveler_unit rfpl_checker u_rfpl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
